>>> hdl/tsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared widths, fixed-point constants and the cell-to-cell bus type for the
// Taylor-series sine/cosine core.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int SERIES_ORDER_DEF = 12;

    localparam int ANGLE_W = 32;   // Q4.28 input angle
    localparam int VALUE_W = 32;   // Q2.30 result
    localparam int ACC_W   = 36;   // signed working width for angles and sums
    localparam int RED_W   = 33;   // reduced angle, [0, 2pi] in Q30
    localparam int X_W     = 31;   // folded angle, [0, pi/2] in Q30
    localparam int TERM_W  = 32;   // unsigned series term, Q30
    localparam int PROD_W  = TERM_W + X_W;
    localparam int FRAC_W  = 30;

    // Reciprocal multiply for the per-cell division by a small constant
    localparam int NUM_W   = 33;
    localparam int RECIP_S = 33;
    localparam int RECIP_W = 34;
    localparam int RPROD_W = NUM_W + RECIP_W;

    localparam logic signed [ACC_W-1:0] ONE_Q30     = 36'sd1073741824;
    localparam logic        [PROD_W-1:0] HALF_LSB   = PROD_W'(64'd536870912);
    localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ACC_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ACC_W-1:0] THR_PI_Q30  = 36'sd5059889139;
    localparam logic signed [ACC_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [ACC_W-1:0] FOUR_PI_Q30 = 36'sd13493037704;

    // Word handed from one cell to the next
    typedef struct packed {
        logic                     valid;
        logic                     odd;    // 1: sine (odd powers)
        logic                     neg;    // quadrant sign
        logic [X_W-1:0]           x;      // folded angle
        logic signed [ACC_W-1:0]  acc;    // partial sum
        logic [TERM_W-1:0]        term;   // latest term, not yet summed
    } t_cell_bus;

endpackage
`default_nettype wire

>>> hdl/tsc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_in_if / tsc_out_if
// Valid/ready channels for the angle words and the result words.
// ----------------------------------------------------------------------------
interface tsc_in_if
    import tsc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [ANGLE_W-1:0]  angle;

    modport source (output valid, output mode, output angle, input ready);
    modport sink   (input valid, input mode, input angle, output ready);
endinterface

interface tsc_out_if
    import tsc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

>>> hdl/tsc_reduce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_reduce
// Three-stage front end: range reduction to [0, 2pi], quadrant fold to
// [0, pi/2], and seeding of the series bus.
// ----------------------------------------------------------------------------
module tsc_reduce
    import tsc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic                       i_valid,
    input  wire logic                       i_mode,
    input  wire logic signed [ANGLE_W-1:0]  i_angle,
    output      t_cell_bus                  o_bus
);

    logic                       r1_valid, r1_mode;
    logic signed [ACC_W-1:0]    r1_a, r1_ap2, r1_ap4, r1_am2;
    logic signed [ACC_W-1:0]    n1_a;

    logic                       r2_valid, r2_mode;
    logic [RED_W-1:0]           r2_red;
    logic signed [ACC_W-1:0]    n2_sel;

    t_cell_bus                  r3_bus, n3_bus;
    logic signed [ACC_W-1:0]    w_red_s;
    logic signed [ACC_W-1:0]    w_x;

    // Stage 1: widen to Q30 and form the wrap candidates
    assign n1_a = ACC_W'(i_angle) <<< 2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r1_mode  <= i_mode;
            r1_a     <= n1_a;
            r1_ap2   <= n1_a + TWO_PI_Q30;
            r1_ap4   <= n1_a + FOUR_PI_Q30;
            r1_am2   <= n1_a - TWO_PI_Q30;
        end
    end

    // Stage 2: pick the candidate; exactly 2pi is kept
    always_comb begin
        if (r1_a < 0) begin
            n2_sel = (r1_ap2 < 0) ? r1_ap4 : r1_ap2;
        end else if (r1_am2 > 0) begin
            n2_sel = r1_am2;
        end else begin
            n2_sel = r1_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid;
            r2_mode  <= r1_mode;
            r2_red   <= RED_W'(n2_sel);
        end
    end

    // Stage 3: fold to the first quadrant
    assign w_red_s = ACC_W'(r2_red);

    always_comb begin
        n3_bus       = '0;
        n3_bus.valid = r2_valid;
        n3_bus.odd   = !r2_mode;
        if (w_red_s <= HALF_PI_Q30) begin
            w_x        = w_red_s;
            n3_bus.neg = 1'b0;
        end else if (w_red_s <= PI_Q30) begin
            w_x        = PI_Q30 - w_red_s;
            n3_bus.neg = r2_mode;
        end else if (w_red_s <= THR_PI_Q30) begin
            w_x        = w_red_s - PI_Q30;
            n3_bus.neg = 1'b1;
        end else begin
            w_x        = TWO_PI_Q30 - w_red_s;
            n3_bus.neg = !r2_mode;
        end
        n3_bus.x    = X_W'(w_x);
        n3_bus.term = TERM_W'(w_x);
        n3_bus.acc  = r2_mode ? ONE_Q30 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_bus.valid <= 1'b0;
        end else if (i_adv) begin
            r3_bus <= n3_bus;
        end
    end

    assign o_bus = r3_bus;

endmodule
`default_nettype wire

>>> hdl/tsc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_cell
// One series cell. Sums the incoming term (power K-1) when its parity
// matches, and builds the term for power K: round(t*x >> 30), then a
// rounded divide by K via reciprocal multiply with one correction step.
// Four stages.
// ----------------------------------------------------------------------------
module tsc_cell
    import tsc_pkg::*;
#(
    parameter int K = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire t_cell_bus  i_bus,
    output t_cell_bus       o_bus
);

    localparam int PWR      = K - 1;
    localparam bit PWR_ODD  = (PWR % 2) == 1;
    localparam bit PWR_NEG  = ((PWR / 2) % 2) == 1;
    localparam logic [NUM_W-1:0]   K_N    = NUM_W'(K);
    localparam logic [NUM_W-1:0]   K_HALF = NUM_W'(K / 2);
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((64'd1 << RECIP_S) / K);

    t_cell_bus              r1_bus, n1_bus;
    logic [PROD_W-1:0]      r1_p;
    t_cell_bus              r2_bus;
    logic [NUM_W-1:0]       r2_n;
    t_cell_bus              r3_bus;
    logic [NUM_W-1:0]       r3_n;
    logic [RPROD_W-1:0]     r3_prod;
    t_cell_bus              r4_bus, n4_bus;

    logic [TERM_W-1:0]      w_q0;
    logic [NUM_W-1:0]       w_rem;

    // Stage 1: accumulate previous term, multiply by x
    always_comb begin
        n1_bus = i_bus;
        if (i_bus.odd == PWR_ODD) begin
            if (PWR_NEG) begin
                n1_bus.acc = i_bus.acc - ACC_W'(i_bus.term);
            end else begin
                n1_bus.acc = i_bus.acc + ACC_W'(i_bus.term);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_bus.valid <= 1'b0;
        end else if (i_adv) begin
            r1_bus <= n1_bus;
            r1_p   <= PROD_W'(i_bus.term) * PROD_W'(i_bus.x);
        end
    end

    // Stage 2: round back to Q30, add K/2 for the rounded divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_bus.valid <= 1'b0;
        end else if (i_adv) begin
            r2_bus <= r1_bus;
            r2_n   <= NUM_W'((r1_p + HALF_LSB) >> FRAC_W) + K_HALF;
        end
    end

    // Stage 3: quotient estimate by reciprocal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_bus.valid <= 1'b0;
        end else if (i_adv) begin
            r3_bus  <= r2_bus;
            r3_n    <= r2_n;
            r3_prod <= RPROD_W'(r2_n) * RPROD_W'(RECIP);
        end
    end

    // Stage 4: estimate is exact or one low; fix it up
    always_comb begin
        w_q0   = TERM_W'(r3_prod >> RECIP_S);
        w_rem  = r3_n - NUM_W'(NUM_W'(w_q0) * K_N);
        n4_bus = r3_bus;
        n4_bus.term = (w_rem >= K_N) ? w_q0 + TERM_W'(1) : w_q0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_bus.valid <= 1'b0;
        end else if (i_adv) begin
            r4_bus <= n4_bus;
        end
    end

    assign o_bus = r4_bus;

endmodule
`default_nettype wire

>>> hdl/tsc_final.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_final
// Adds the last term, saturates to +/-1 and applies the quadrant sign.
// The second stage is the output register.
// ----------------------------------------------------------------------------
module tsc_final
    import tsc_pkg::*;
#(
    parameter int PWR = SERIES_ORDER_DEF - 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire t_cell_bus                  i_bus,
    output      logic                       o_valid,
    output      logic signed [VALUE_W-1:0]  o_value
);

    localparam bit PWR_ODD = (PWR % 2) == 1;
    localparam bit PWR_NEG = ((PWR / 2) % 2) == 1;

    logic                       r1_valid, r1_neg;
    logic signed [ACC_W-1:0]    r1_acc, n1_acc;
    logic                       r2_valid;
    logic signed [VALUE_W-1:0]  r2_value;
    logic signed [ACC_W-1:0]    w_sat, w_res;

    always_comb begin
        n1_acc = i_bus.acc;
        if (i_bus.odd == PWR_ODD) begin
            if (PWR_NEG) begin
                n1_acc = i_bus.acc - ACC_W'(i_bus.term);
            end else begin
                n1_acc = i_bus.acc + ACC_W'(i_bus.term);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_bus.valid;
            r1_neg   <= i_bus.neg;
            r1_acc   <= n1_acc;
        end
    end

    always_comb begin
        if (r1_acc > ONE_Q30) begin
            w_sat = ONE_Q30;
        end else if (r1_acc < -ONE_Q30) begin
            w_sat = -ONE_Q30;
        end else begin
            w_sat = r1_acc;
        end
        w_res = r1_neg ? -w_sat : w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid;
            r2_value <= VALUE_W'(w_res);
        end
    end

    assign o_valid = r2_valid;
    assign o_value = r2_value;

endmodule
`default_nettype wire

>>> hdl/taylor_sine_cosine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// taylor_sine_cosine_core
// Sine or cosine of a Q4.28 angle by a fixed-order Taylor series, built as
// a row of parameterised term cells behind a range-reduction front end.
// ----------------------------------------------------------------------------
//  channel  | dir | word fields                    | notes
//  ---------+-----+--------------------------------+---------------------------
//  i_in     | in  | mode (0 sin, 1 cos), angle Q4.28 | valid/ready
//  o_out    | out | value Q2.30, within +/-1        | valid/ready, registered
//
//  Throughput is one word per cycle while the output is not stalled. The
//  pipeline holds 3 reduction stages, 4 per term cell (SERIES_ORDER-2
//  cells) and 2 for the final sum and sign.
//  The whole row moves on one advance signal: it steps whenever the output
//  register is empty or being taken, so a word is accepted in the same
//  cycle a finished result leaves. A stalled output freezes every stage.
//  Reset (synchronous, active low) clears only the stage valid bits.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_core
    import tsc_pkg::*;
#(
    parameter int SERIES_ORDER = SERIES_ORDER_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tsc_in_if.sink      i_in,
    tsc_out_if.source   o_out
);

    localparam int NUM_CELLS = SERIES_ORDER - 2;

    logic       w_adv;
    logic       w_out_valid;
    t_cell_bus  w_bus [NUM_CELLS+1];

    // Pipeline advances when the output slot is free or being drained
    assign w_adv      = !w_out_valid || o_out.ready;
    assign i_in.ready = w_adv;

    // Reduce to [0, 2pi], fold to [0, pi/2], seed the sum with the
    // power-0 term and the pending term with the power-1 term x
    tsc_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in.valid),
        .i_mode  (i_in.mode),
        .i_angle (i_in.angle),
        .o_bus   (w_bus[0])
    );

    // Cell g forms the term for power g+2 and sums power g+1
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        tsc_cell #(
            .K (g + 2)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_bus   (w_bus[g]),
            .o_bus   (w_bus[g+1])
        );
    end

    // Last term, saturation, quadrant sign; holds the output register
    tsc_final #(
        .PWR (SERIES_ORDER - 1)
    ) u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_bus   (w_bus[NUM_CELLS]),
        .o_valid (w_out_valid),
        .o_value (o_out.value)
    );

    assign o_out.valid = w_out_valid;

endmodule
`default_nettype wire
